@@ design/ep2c_pkg.sv @@
`default_nettype none
package ep2c_pkg;

	localparam int unsigned SEC_W  = 32;
	localparam int unsigned DAYS_W = 16;
	localparam int unsigned HOUR_W = 5;
	localparam int unsigned MIN_W  = 6;
	localparam int unsigned SECW   = 6;
	localparam int unsigned YEAR_W = 12;
	localparam int unsigned MON_W  = 4;
	localparam int unsigned DOM_W  = 5;
	localparam int unsigned CNT_W  = 4;

	localparam logic [SEC_W-1:0] SECS_PER_DAY  = SEC_W'(60 * 60 * 24);
	localparam logic [SEC_W-1:0] SECS_PER_HOUR = SEC_W'(60 * 60);
	localparam logic [SEC_W-1:0] SECS_PER_MIN  = SEC_W'(60);

	localparam logic [YEAR_W-1:0] BASE_YEAR  = YEAR_W'(1970);
	localparam logic [1:0]        BASE_Y4    = 2'(1970 % 4);
	localparam logic [6:0]        BASE_Y100  = 7'(1970 % 100);
	localparam logic [8:0]        BASE_Y400  = 9'(1970 % 400);
	localparam logic [SEC_W-1:0]  DAYS_LEAP  = SEC_W'(366);
	localparam logic [SEC_W-1:0]  DAYS_COMMON = SEC_W'(365);

	localparam logic [CNT_W-1:0] DAYS_LAST_BIT = CNT_W'(DAYS_W - 1);
	localparam logic [CNT_W-1:0] HOUR_LAST_BIT = CNT_W'(HOUR_W - 1);
	localparam logic [CNT_W-1:0] MIN_LAST_BIT  = CNT_W'(MIN_W - 1);
	localparam logic [MON_W-1:0] LAST_MONTH    = MON_W'(11);

	localparam logic [8:0] MONTH_END_COMMON [12] =
		'{9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
		  9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365};
	localparam logic [8:0] MONTH_END_LEAP [12] =
		'{9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182,
		  9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366};

	typedef enum logic [2:0] {
		S_IDLE,
		S_DAYS,
		S_HOUR,
		S_MIN,
		S_YEAR,
		S_MONTH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [DOM_W-1:0]  day_of_month;
		logic [MON_W-1:0]  month_number;
		logic [YEAR_W-1:0] year_number;
		logic [HOUR_W-1:0] hour_of_day;
		logic [MIN_W-1:0]  minute_of_hour;
		logic [SECW-1:0]   second_of_minute;
	} result_t;

	// length of month m, taken from the cumulative tables
	function automatic logic [4:0] month_len(input logic leap, input logic [MON_W-1:0] m);
		logic [8:0] cur;
		logic [8:0] prev;
		cur  = leap ? MONTH_END_LEAP[m] : MONTH_END_COMMON[m];
		prev = 9'd0;
		if (m != '0)
			prev = leap ? MONTH_END_LEAP[m - MON_W'(1)] : MONTH_END_COMMON[m - MON_W'(1)];
		month_len = 5'(cur - prev);
	endfunction

endpackage
`default_nettype wire

@@ design/ep2c_req_if.sv @@
`default_nettype none
interface ep2c_req_if import ep2c_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEC_W-1:0] epoch_seconds;

	modport source (output valid, output epoch_seconds, input ready);
	modport sink (input valid, input epoch_seconds, output ready);
endinterface
`default_nettype wire

@@ design/ep2c_rsp_if.sv @@
`default_nettype none
interface ep2c_rsp_if import ep2c_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DOM_W-1:0]  day_of_month;
	logic [MON_W-1:0]  month_number;
	logic [YEAR_W-1:0] year_number;
	logic [HOUR_W-1:0] hour_of_day;
	logic [MIN_W-1:0]  minute_of_hour;
	logic [SECW-1:0]   second_of_minute;

	modport source (output valid, output day_of_month, output month_number,
		output year_number, output hour_of_day, output minute_of_hour,
		output second_of_minute, input ready);
	modport sink (input valid, input day_of_month, input month_number,
		input year_number, input hour_of_day, input minute_of_hour,
		input second_of_minute, output ready);
endinterface
`default_nettype wire

@@ design/ep2c_sub.sv @@
`default_nettype none
module ep2c_sub import ep2c_pkg::*; (
	input  wire logic [SEC_W-1:0] a,
	input  wire logic [SEC_W-1:0] b,
	output logic      [SEC_W-1:0] diff,
	output logic                  ge
);
	logic [SEC_W:0] full;

	assign full = {1'b0, a} - {1'b0, b};
	assign diff = full[SEC_W-1:0];
	assign ge   = ~full[SEC_W];
endmodule
`default_nettype wire

@@ design/ep2c_core.sv @@
`default_nettype none
module ep2c_core import ep2c_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SEC_W-1:0] secs,
	input  wire logic             ack,
	output logic                  idle,
	output logic                  done,
	output result_t               res
);
	state_t state_q, state_d;

	logic [SEC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DAYS_W-1:0] days_q;
	logic [HOUR_W-1:0] hour_q;
	logic [MIN_W-1:0]  min_q;
	logic [SECW-1:0]   sec_q;
	logic [YEAR_W-1:0] year_q;
	logic [1:0]        y4_q;
	logic [6:0]        y100_q;
	logic [8:0]        y400_q;
	logic [MON_W-1:0]  mon_q;

	logic [SEC_W-1:0] opnd;
	logic [SEC_W-1:0] diff;
	logic             ge;
	logic             leap;
	logic [SEC_W-1:0] acc_nx;

	assign leap   = ((y4_q == 2'd0) && (y100_q != 7'd0)) || (y400_q == 9'd0);
	assign acc_nx = ge ? diff : acc_q;

	always_comb begin
		unique case (state_q)
			S_DAYS:  opnd = SECS_PER_DAY << cnt_q;
			S_HOUR:  opnd = SECS_PER_HOUR << cnt_q;
			S_MIN:   opnd = SECS_PER_MIN << cnt_q;
			S_YEAR:  opnd = leap ? DAYS_LEAP : DAYS_COMMON;
			S_MONTH: opnd = SEC_W'(month_len(leap, mon_q));
			default: opnd = '0;
		endcase
	end

	ep2c_sub u_sub (
		.a    (acc_q),
		.b    (opnd),
		.diff (diff),
		.ge   (ge)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_DAYS;
			S_DAYS:  if (cnt_q == '0) state_d = S_HOUR;
			S_HOUR:  if (cnt_q == '0) state_d = S_MIN;
			S_MIN:   if (cnt_q == '0) state_d = S_YEAR;
			S_YEAR:  if (!ge) state_d = S_MONTH;
			S_MONTH: if (!ge || mon_q == LAST_MONTH) state_d = S_DONE;
			S_DONE:  if (ack) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		idle = (state_q == S_IDLE);
		done = (state_q == S_DONE);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					acc_q <= secs;
					cnt_q <= DAYS_LAST_BIT;
				end
			end
			S_DAYS: begin
				acc_q  <= acc_nx;
				days_q <= {days_q[DAYS_W-2:0], ge};
				cnt_q  <= (cnt_q == '0) ? HOUR_LAST_BIT : cnt_q - CNT_W'(1);
			end
			S_HOUR: begin
				acc_q  <= acc_nx;
				hour_q <= {hour_q[HOUR_W-2:0], ge};
				cnt_q  <= (cnt_q == '0) ? MIN_LAST_BIT : cnt_q - CNT_W'(1);
			end
			S_MIN: begin
				min_q <= {min_q[MIN_W-2:0], ge};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					sec_q  <= acc_nx[SECW-1:0];
					acc_q  <= SEC_W'(days_q);
					year_q <= BASE_YEAR;
					y4_q   <= BASE_Y4;
					y100_q <= BASE_Y100;
					y400_q <= BASE_Y400;
					mon_q  <= '0;
				end else begin
					acc_q <= acc_nx;
				end
			end
			S_YEAR: begin
				if (ge) begin
					acc_q  <= diff;
					year_q <= year_q + YEAR_W'(1);
					y4_q   <= y4_q + 2'd1;
					y100_q <= (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
					y400_q <= (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
				end
			end
			S_MONTH: begin
				if (ge && mon_q != LAST_MONTH) begin
					acc_q <= diff;
					mon_q <= mon_q + MON_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.day_of_month     = acc_q[DOM_W-1:0] + DOM_W'(1);
		res.month_number     = mon_q + MON_W'(1);
		res.year_number      = year_q;
		res.hour_of_day      = hour_q;
		res.minute_of_hour   = min_q;
		res.second_of_minute = sec_q;
	end

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MONTH) |-> (mon_q <= LAST_MONTH))
		else $error("month index out of range");

	a_year_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_YEAR) |-> (year_q <= YEAR_W'(2106)))
		else $error("year count overran");

	a_leap_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_YEAR || state_q == S_MONTH) |-> (y4_q == year_q[1:0]))
		else $error("mod-4 counter out of step with year");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !ack) |=> (done && $stable(res)))
		else $error("result changed before hand-off");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !idle) |-> 1'b0)
		else $error("request taken while busy");
endmodule
`default_nettype wire

@@ design/epoch_seconds_to_calendar.sv @@
// Converts an unsigned 32-bit Unix time into a Gregorian date and time of day
// (1970-01-01 00:00:00 up to 2106-02-07 06:28:15). One request is worked at a
// time by a single 32-bit compare-and-subtract unit: long division by 86400 for
// the day count, then by 3600 for the hour and by 60 for the minute, then the
// days of each elapsed year and then of each month passed are subtracted one at
// a time. The result sits in an output register, so a new request is taken
// while it waits.
`default_nettype none
module epoch_seconds_to_calendar import ep2c_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ep2c_req_if.sink  req,
	ep2c_rsp_if.source rsp
);
	logic    core_idle;
	logic    core_done;
	logic    load;
	logic    rsp_valid_q;
	result_t core_res;
	result_t res_q;

	assign req.ready = core_idle;
	assign load      = core_done && (!rsp_valid_q || rsp.ready);

	ep2c_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (req.valid && core_idle),
		.secs   (req.epoch_seconds),
		.ack    (load),
		.idle   (core_idle),
		.done   (core_done),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (load)
			rsp_valid_q <= 1'b1;
		else if (rsp.ready)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= core_res;
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.day_of_month     = res_q.day_of_month;
	assign rsp.month_number     = res_q.month_number;
	assign rsp.year_number      = res_q.year_number;
	assign rsp.hour_of_day      = res_q.hour_of_day;
	assign rsp.minute_of_hour   = res_q.minute_of_hour;
	assign rsp.second_of_minute = res_q.second_of_minute;
endmodule
`default_nettype wire
